>>> src/lpht_pkg.sv
// Shared types and constants for the linear-probing hash table.
package lpht_pkg;

    localparam int NUMBER_BITS = 32;
    localparam int TAG_BITS    = 32;
    localparam int SLOT_BITS   = 4;
    localparam int COUNT_BITS  = 5;
    localparam int DIGIT_BITS  = 8;

    localparam logic REQ_INSERT = 1'b0;
    localparam logic REQ_FIND   = 1'b1;

    localparam logic [1:0] ST_INSERTED  = 2'd0;
    localparam logic [1:0] ST_FULL      = 2'd1;
    localparam logic [1:0] ST_FOUND     = 2'd2;
    localparam logic [1:0] ST_NOT_FOUND = 2'd3;

    typedef struct packed {
        logic                   req_type;
        logic [NUMBER_BITS-1:0] number;
        logic [TAG_BITS-1:0]    name_tag;
    } req_t;

    typedef struct packed {
        logic [1:0]            status;
        logic [SLOT_BITS-1:0]  slot;
        logic [COUNT_BITS-1:0] probe_count;
    } rsp_t;

endpackage

>>> src/linear_probe_hash_table.sv
// Top level: open-addressing hash table with linear probing and request sequencer.
//
//  channel  | handshake                    | word
//  ---------+------------------------------+------------------------------------------
//  request  | req_valid / req_ready        | req : req_t (req_type, number, name_tag)
//  response | rsp_valid / rsp_ready        | rsp : rsp_t (status, slot, probe_count)
//  config   | cfg_valid / cfg_ready (=1)   | cfg_data : replace_mode
//
//  One request at a time. The home slot comes from a shared remainder unit, reducing the
//  32-bit number a byte at a time, used a second time in replace mode for the occupant's home.
//  Find: compares one slot per cycle, with the memory read pipelined.
//  Insert: writes a free home slot directly, else probes past the occupied slots, with
//  an occupant read and rehash added in replace mode; a full table answers without hashing.
//  Reset clears the occupied flags and entry count at once; no clearing pass.
//  A response waiting on rsp_ready holds the output register; the next request is
//  still taken and stalls only when its own answer is ready.
module linear_probe_hash_table
    import lpht_pkg::*;
#(
    parameter int TABLE_SIZE = 16,
    parameter int NAME_BITS  = 32
)
(
    input  logic clk,
    input  logic rst_n,
    input  logic req_valid,
    output logic req_ready,
    input  req_t req,
    output logic rsp_valid,
    input  logic rsp_ready,
    output rsp_t rsp,
    input  logic cfg_valid,
    output logic cfg_ready,
    input  logic cfg_data
);

    localparam int IW = $clog2(TABLE_SIZE);
    localparam int CW = $clog2(TABLE_SIZE + 1);

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_HASH  = 3'd1;
    localparam logic [2:0] S_FIND  = 3'd2;
    localparam logic [2:0] S_RDOLD = 3'd3;
    localparam logic [2:0] S_HASH2 = 3'd4;
    localparam logic [2:0] S_PROBE = 3'd5;
    localparam logic [2:0] S_FIN   = 3'd6;

    logic [2:0]             state_reg,        state_next;
    logic                   replace_mode_reg, replace_mode_next;
    logic [CW-1:0]          entry_count_reg,  entry_count_next;
    logic [NUMBER_BITS-1:0] number_reg,       number_next;
    logic [NAME_BITS-1:0]   name_reg,         name_next;
    logic                   find_reg,         find_next;
    logic [IW-1:0]          home_reg,         home_next;
    logic [NUMBER_BITS-1:0] old_number_reg,   old_number_next;
    logic [NAME_BITS-1:0]   old_name_reg,     old_name_next;
    logic [IW-1:0]          idx_reg,          idx_next;
    logic [CW-1:0]          cnt_reg,          cnt_next;
    logic                   cmp_vld_reg,      cmp_vld_next;
    logic [IW-1:0]          cmp_idx_reg,      cmp_idx_next;
    logic [CW-1:0]          cmp_n_reg,        cmp_n_next;
    logic                   repl_reg,         repl_next;
    rsp_t                   pend_reg,         pend_next;
    rsp_t                   rsp_reg,          rsp_next;
    logic                   rsp_valid_reg,    rsp_valid_next;

    logic                   mod_start;
    logic [NUMBER_BITS-1:0] mod_operand;
    logic                   mod_done;
    logic [IW-1:0]          mod_result;

    logic                   wr_en;
    logic [IW-1:0]          wr_addr;
    logic [NUMBER_BITS-1:0] wr_number;
    logic [NAME_BITS-1:0]   wr_name;
    logic                   rd_en;
    logic [IW-1:0]          rd_addr;
    logic [NUMBER_BITS-1:0] rd_number;
    logic [NAME_BITS-1:0]   rd_name;
    logic [IW-1:0]          occ_addr;
    logic                   occ_bit;
    logic                   match;

    function automatic logic [IW-1:0] next_slot(input logic [IW-1:0] s);
        next_slot = (s == IW'(TABLE_SIZE - 1)) ? '0 : s + 1'b1;
    endfunction

    lpht_mod #(
        .TABLE_SIZE (TABLE_SIZE)
    ) u_mod (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (mod_start),
        .operand (mod_operand),
        .done    (mod_done),
        .result  (mod_result)
    );

    lpht_store #(
        .TABLE_SIZE (TABLE_SIZE),
        .NAME_BITS  (NAME_BITS)
    ) u_store (
        .clk       (clk),
        .rst_n     (rst_n),
        .wr_en     (wr_en),
        .wr_addr   (wr_addr),
        .wr_number (wr_number),
        .wr_name   (wr_name),
        .rd_en     (rd_en),
        .rd_addr   (rd_addr),
        .rd_number (rd_number),
        .rd_name   (rd_name),
        .occ_addr  (occ_addr),
        .occ_bit   (occ_bit)
    );

    assign req_ready   = (state_reg == S_IDLE);
    assign cfg_ready   = 1'b1;
    assign rsp_valid   = rsp_valid_reg;
    assign rsp         = rsp_reg;
    assign mod_operand = (state_reg == S_IDLE) ? req.number : rd_number;
    assign match       = cmp_vld_reg && occ_bit && (rd_name == name_reg);

    always_comb
    begin
        state_next        = state_reg;
        replace_mode_next = replace_mode_reg;
        entry_count_next  = entry_count_reg;
        number_next       = number_reg;
        name_next         = name_reg;
        find_next         = find_reg;
        home_next         = home_reg;
        old_number_next   = old_number_reg;
        old_name_next     = old_name_reg;
        idx_next          = idx_reg;
        cnt_next          = cnt_reg;
        cmp_vld_next      = cmp_vld_reg;
        cmp_idx_next      = cmp_idx_reg;
        cmp_n_next        = cmp_n_reg;
        repl_next         = repl_reg;
        pend_next         = pend_reg;
        rsp_next          = rsp_reg;
        rsp_valid_next    = rsp_valid_reg;
        mod_start         = 1'b0;
        wr_en             = 1'b0;
        wr_addr           = home_reg;
        wr_number         = number_reg;
        wr_name           = name_reg;
        rd_en             = 1'b0;
        rd_addr           = idx_reg;
        occ_addr          = idx_reg;

        if (cfg_valid)
        begin
            replace_mode_next = cfg_data;
        end

        if (rsp_valid_reg && rsp_ready)
        begin
            rsp_valid_next = 1'b0;
        end

        unique case (state_reg)
            S_IDLE:
            begin
                if (req_valid)
                begin
                    number_next = req.number;
                    name_next   = NAME_BITS'(req.name_tag);
                    find_next   = (req.req_type == REQ_FIND);
                    if (req.req_type == REQ_INSERT && entry_count_reg == CW'(TABLE_SIZE))
                    begin
                        pend_next  = '{status: ST_FULL, slot: '0, probe_count: '0};
                        state_next = S_FIN;
                    end
                    else
                    begin
                        mod_start  = 1'b1;
                        state_next = S_HASH;
                    end
                end
            end

            S_HASH:
            begin
                occ_addr = mod_result;
                if (mod_done)
                begin
                    home_next    = mod_result;
                    idx_next     = mod_result;
                    cnt_next     = '0;
                    cmp_vld_next = 1'b0;
                    repl_next    = 1'b0;
                    if (find_reg)
                    begin
                        state_next = S_FIND;
                    end
                    else if (!occ_bit)
                    begin
                        wr_en            = 1'b1;
                        wr_addr          = mod_result;
                        entry_count_next = entry_count_reg + 1'b1;
                        pend_next        = '{status: ST_INSERTED,
                                             slot: SLOT_BITS'(mod_result),
                                             probe_count: '0};
                        state_next       = S_FIN;
                    end
                    else if (replace_mode_reg)
                    begin
                        rd_en      = 1'b1;
                        rd_addr    = mod_result;
                        state_next = S_RDOLD;
                    end
                    else
                    begin
                        state_next = S_PROBE;
                    end
                end
            end

            // Issue one read per cycle; compare the word returned from the previous read
            S_FIND:
            begin
                occ_addr = cmp_idx_reg;
                if (cnt_reg != CW'(TABLE_SIZE))
                begin
                    rd_en        = 1'b1;
                    rd_addr      = idx_reg;
                    cmp_vld_next = 1'b1;
                    cmp_idx_next = idx_reg;
                    cmp_n_next   = cnt_reg + 1'b1;
                    idx_next     = next_slot(idx_reg);
                    cnt_next     = cnt_reg + 1'b1;
                end
                else
                begin
                    cmp_vld_next = 1'b0;
                end
                if (match)
                begin
                    pend_next  = '{status: ST_FOUND,
                                   slot: SLOT_BITS'(cmp_idx_reg),
                                   probe_count: COUNT_BITS'(cmp_n_reg)};
                    state_next = S_FIN;
                end
                else if (cmp_vld_reg && cmp_n_reg == CW'(TABLE_SIZE))
                begin
                    pend_next  = '{status: ST_NOT_FOUND,
                                   slot: '0,
                                   probe_count: COUNT_BITS'(TABLE_SIZE)};
                    state_next = S_FIN;
                end
            end

            S_RDOLD:
            begin
                old_number_next = rd_number;
                old_name_next   = rd_name;
                mod_start       = 1'b1;
                state_next      = S_HASH2;
            end

            // Take over the home slot only from an occupant that belongs elsewhere
            S_HASH2:
            begin
                if (mod_done)
                begin
                    if (mod_result != home_reg)
                    begin
                        wr_en     = 1'b1;
                        wr_addr   = home_reg;
                        repl_next = 1'b1;
                    end
                    state_next = S_PROBE;
                end
            end

            S_PROBE:
            begin
                occ_addr = idx_reg;
                if (occ_bit && cnt_reg != CW'(TABLE_SIZE))
                begin
                    idx_next = next_slot(idx_reg);
                    cnt_next = cnt_reg + 1'b1;
                end
                else
                begin
                    wr_en            = 1'b1;
                    wr_addr          = idx_reg;
                    wr_number        = repl_reg ? old_number_reg : number_reg;
                    wr_name          = repl_reg ? old_name_reg : name_reg;
                    entry_count_next = entry_count_reg + 1'b1;
                    pend_next        = '{status: ST_INSERTED,
                                         slot: repl_reg ? SLOT_BITS'(home_reg)
                                                        : SLOT_BITS'(idx_reg),
                                         probe_count: COUNT_BITS'(cnt_reg)};
                    state_next       = S_FIN;
                end
            end

            // Hold the answer until the output register frees up
            S_FIN:
            begin
                if (!rsp_valid_reg || rsp_ready)
                begin
                    rsp_next       = pend_reg;
                    rsp_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= S_IDLE;
            replace_mode_reg <= 1'b0;
            entry_count_reg  <= '0;
            find_reg         <= 1'b0;
            cmp_vld_reg      <= 1'b0;
            repl_reg         <= 1'b0;
            rsp_valid_reg    <= 1'b0;
        end
        else
        begin
            state_reg        <= state_next;
            replace_mode_reg <= replace_mode_next;
            entry_count_reg  <= entry_count_next;
            find_reg         <= find_next;
            cmp_vld_reg      <= cmp_vld_next;
            repl_reg         <= repl_next;
            rsp_valid_reg    <= rsp_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        number_reg     <= number_next;
        name_reg       <= name_next;
        home_reg       <= home_next;
        old_number_reg <= old_number_next;
        old_name_reg   <= old_name_next;
        idx_reg        <= idx_next;
        cnt_reg        <= cnt_next;
        cmp_idx_reg    <= cmp_idx_next;
        cmp_n_reg      <= cmp_n_next;
        pend_reg       <= pend_next;
        rsp_reg        <= rsp_next;
    end

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        entry_count_reg <= CW'(TABLE_SIZE))
        else $error("entry count beyond table size");

    a_no_write_when_full: assert property (@(posedge clk) disable iff (!rst_n)
        (wr_en && state_reg != S_HASH2) |-> (entry_count_reg != CW'(TABLE_SIZE)))
        else $error("slot written with table full");

    a_done_while_hashing: assert property (@(posedge clk) disable iff (!rst_n)
        mod_done |-> (state_reg == S_HASH || state_reg == S_HASH2))
        else $error("remainder unit finished outside a hash state");

    a_probe_has_room: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_PROBE) |-> (cnt_reg != CW'(TABLE_SIZE)))
        else $error("probe walked the whole table");

endmodule

>>> src/lpht_mod.sv
// Iterative remainder unit: number mod TABLE_SIZE, one byte per cycle.
module lpht_mod
    import lpht_pkg::*;
#(
    parameter int TABLE_SIZE = 16
)
(
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            start,
    input  logic [NUMBER_BITS-1:0]          operand,
    output logic                            done,
    output logic [$clog2(TABLE_SIZE)-1:0]   result
);

    localparam int IW    = $clog2(TABLE_SIZE);
    localparam int VW    = IW + DIGIT_BITS;
    localparam int STEPS = NUMBER_BITS / DIGIT_BITS;
    localparam int SW    = $clog2(STEPS);

    logic [NUMBER_BITS-1:0] opr_reg;
    logic [IW-1:0]          rem_reg;
    logic [SW-1:0]          step_reg;
    logic                   busy_reg;
    logic                   done_reg;
    logic [VW-1:0]          val;
    logic [IW-1:0]          rem_step;
    logic                   last_step;

    // Restoring reduction of {remainder, next byte}
    always_comb
    begin
        val = {rem_reg, opr_reg[NUMBER_BITS-1 -: DIGIT_BITS]};
        for (int k = DIGIT_BITS - 1; k >= 0; k--)
        begin
            if (val >= (VW'(TABLE_SIZE) << k))
            begin
                val = val - (VW'(TABLE_SIZE) << k);
            end
        end
        rem_step = IW'(val);
    end

    assign last_step = (step_reg == SW'(STEPS - 1));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            step_reg <= '0;
        end
        else
        begin
            done_reg <= busy_reg && last_step;
            if (start)
            begin
                busy_reg <= 1'b1;
                step_reg <= '0;
            end
            else if (busy_reg)
            begin
                step_reg <= step_reg + 1'b1;
                if (last_step)
                begin
                    busy_reg <= 1'b0;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            opr_reg <= operand;
            rem_reg <= '0;
        end
        else if (busy_reg)
        begin
            opr_reg <= opr_reg << DIGIT_BITS;
            rem_reg <= rem_step;
        end
    end

    assign done   = done_reg;
    assign result = rem_reg;

endmodule

>>> src/lpht_store.sv
// Slot storage: entry memory with registered read, plus per-slot occupied flags.
module lpht_store
    import lpht_pkg::*;
#(
    parameter int TABLE_SIZE = 16,
    parameter int NAME_BITS  = 32
)
(
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            wr_en,
    input  logic [$clog2(TABLE_SIZE)-1:0]   wr_addr,
    input  logic [NUMBER_BITS-1:0]          wr_number,
    input  logic [NAME_BITS-1:0]            wr_name,
    input  logic                            rd_en,
    input  logic [$clog2(TABLE_SIZE)-1:0]   rd_addr,
    output logic [NUMBER_BITS-1:0]          rd_number,
    output logic [NAME_BITS-1:0]            rd_name,
    input  logic [$clog2(TABLE_SIZE)-1:0]   occ_addr,
    output logic                            occ_bit
);

    logic [NUMBER_BITS-1:0] num_mem  [TABLE_SIZE];
    logic [NAME_BITS-1:0]   name_mem [TABLE_SIZE];
    logic [NUMBER_BITS-1:0] rd_number_reg;
    logic [NAME_BITS-1:0]   rd_name_reg;
    logic [TABLE_SIZE-1:0]  occ_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            num_mem[wr_addr]  <= wr_number;
            name_mem[wr_addr] <= wr_name;
        end
        if (rd_en)
        begin
            rd_number_reg <= num_mem[rd_addr];
            rd_name_reg   <= name_mem[rd_addr];
        end
    end

    // Slots are never freed; reset clears all flags at once
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            occ_reg <= '0;
        end
        else if (wr_en)
        begin
            occ_reg[wr_addr] <= 1'b1;
        end
    end

    assign rd_number = rd_number_reg;
    assign rd_name   = rd_name_reg;
    assign occ_bit   = occ_reg[occ_addr];

endmodule
